// File: sv/aig_pkg.sv
`timescale 1ns / 1ps
package aig_pkg;

  typedef enum logic [4:0] {
    S_EXPAND = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_ROUND  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  localparam int unsigned NumRoundKeys = 15;
  localparam int unsigned LastStep = 14;
  localparam int unsigned LastSchedWord = 59;

  localparam logic [2:0] CFG_KEY_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_3 = 3'd3;
  localparam logic [2:0] CFG_IV_0  = 3'd4;
  localparam logic [2:0] CFG_IV_1  = 3'd5;
  localparam logic [2:0] CFG_IV_2  = 3'd6;
  localparam logic [2:0] CFG_IV_3  = 3'd7;

  // entry 0 in the top byte
  localparam logic [2047:0] SBOX_TABLE = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [10:0] idx;
    idx = {x, 3'b000};
    return SBOX_TABLE[11'd2047 - idx -: 8];
  endfunction

  function automatic logic [2047:0] build_inv_table();
    logic [2047:0] tbl;
    logic [7:0]    v;
    logic [10:0]   idx;
    tbl = '0;
    for (int i = 0; i < 256; i++) begin
      v = sbox(i[7:0]);
      idx = {v, 3'b000};
      tbl[11'd2047 - idx -: 8] = i[7:0];
    end
    return tbl;
  endfunction

  localparam logic [2047:0] INV_SBOX_TABLE = build_inv_table();

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [10:0] idx;
    idx = {x, 3'b000};
    return INV_SBOX_TABLE[11'd2047 - idx -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] d [4];
    for (int k = 0; k < 4; k++) a[k] = c[8*k +: 8];
    for (int k = 0; k < 4; k++) begin
      d[k] = xtime(a[k]) ^ xtime(a[(k+1)%4]) ^ a[(k+1)%4] ^ a[(k+2)%4] ^ a[(k+3)%4];
    end
    return {d[3], d[2], d[1], d[0]};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] d [4];
    for (int k = 0; k < 4; k++) begin
      a[k] = c[8*k +: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m9[k] = x8[k] ^ a[k];
      m11[k] = x8[k] ^ x2[k] ^ a[k];
      m13[k] = x8[k] ^ x4[k] ^ a[k];
      m14[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int k = 0; k < 4; k++) begin
      d[k] = m14[k] ^ m11[(k+1)%4] ^ m13[(k+2)%4] ^ m9[(k+3)%4];
    end
    return {d[3], d[2], d[1], d[0]};
  endfunction

endpackage

// File: sv/aes256_ige_cipher_unit.sv
`timescale 1ns / 1ps
// aes-256 in ige chaining, one 128-bit word in, one out. a single aes round
// unit is reused for every round: the result word shows after one round key
// read and 15 round-unit steps, and is held until it is taken. the next block
// can be taken from the cycle after the result word has left, so a new block
// is never taken before the last result has gone. after reset and after every
// key register write the key schedule is rebuilt, one 32-bit schedule word
// per cycle, while in_stall stays high and cfg_ready is low.
// a pending config write holds off the input for that cycle.
module aes256_ige_cipher_unit
  import aig_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic        decrypt,
  input  logic        first_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_low,
  output logic [63:0] result_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state;

  logic [63:0]  key_word [4];
  logic [63:0]  iv_word  [4];
  logic [127:0] chain_before;
  logic [127:0] chain_after;
  logic [127:0] blk;
  logic [127:0] st;
  logic         dec;
  logic [3:0]   step;

  logic [127:0] rk_mem [NumRoundKeys];
  logic [127:0] rk;
  logic [3:0]   rd_addr;

  logic [5:0]   sched_idx;
  logic [31:0]  win [8];
  logic [7:0]   rcon;
  logic [31:0]  new_word;
  logic [31:0]  tw;

  logic [127:0] st_next;
  logic         last_step;
  logic         in_acc;
  logic         cfg_acc;

  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = (state == S_OUT);
  assign last_step = (step == 4'(LastStep));

  // key schedule word
  always_comb begin
    tw = win[7];
    if (sched_idx[2:0] == 3'd0) begin
      tw = sub_word({tw[7:0], tw[31:8]}) ^ {24'h0, rcon};
    end else if (sched_idx[2:0] == 3'd4) begin
      tw = sub_word(tw);
    end
    if (sched_idx < 6'd8) begin
      new_word = key_word[sched_idx[2:1]][32*sched_idx[0] +: 32];
    end else begin
      new_word = win[0] ^ tw;
    end
  end

  // round key address for the step after the current one
  always_comb begin
    if (state == S_READ) begin
      rd_addr = dec ? 4'(LastStep) : 4'd0;
    end else if (last_step) begin
      rd_addr = 4'd0;
    end else begin
      rd_addr = dec ? 4'(LastStep - 1) - step : step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    rk <= rk_mem[rd_addr];
    if (state == S_EXPAND && sched_idx[1:0] == 2'd3) begin
      rk_mem[sched_idx[5:2]] <= {new_word, win[7], win[6], win[5]};
    end
  end

  // shared round unit
  always_comb begin
    logic [7:0]  sb [16];
    logic [7:0]  sh [16];
    logic [127:0] tmp;
    for (int n = 0; n < 16; n++) begin
      sb[n] = '0;
      sh[n] = '0;
    end
    tmp = '0;
    if (step == 4'd0) begin
      st_next = st ^ rk;
    end else if (!dec) begin
      for (int n = 0; n < 16; n++) sb[n] = sbox(st[8*n +: 8]);
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) sh[r + 4*c] = sb[r + 4*((c + r) % 4)];
      end
      for (int n = 0; n < 16; n++) tmp[8*n +: 8] = sh[n];
      if (!last_step) begin
        for (int c = 0; c < 4; c++) tmp[32*c +: 32] = mix_col(tmp[32*c +: 32]);
      end
      st_next = tmp ^ rk;
    end else begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) sh[r + 4*((c + r) % 4)] = st[8*(r + 4*c) +: 8];
      end
      for (int n = 0; n < 16; n++) tmp[8*n +: 8] = inv_sbox(sh[n]);
      tmp = tmp ^ rk;
      if (!last_step) begin
        for (int c = 0; c < 4; c++) tmp[32*c +: 32] = inv_mix_col(tmp[32*c +: 32]);
      end
      st_next = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EXPAND;
      sched_idx <= '0;
      rcon <= 8'h01;
      step <= '0;
      for (int k = 0; k < 4; k++) begin
        key_word[k] <= '0;
        iv_word[k] <= '0;
      end
      chain_before <= '0;
      chain_after <= '0;
    end else begin
      if (cfg_acc) begin
        if (cfg_index <= CFG_KEY_3) begin
          key_word[cfg_index[1:0]] <= cfg_data;
          state <= S_EXPAND;
          sched_idx <= '0;
          rcon <= 8'h01;
        end else begin
          case (cfg_index)
            CFG_IV_0: iv_word[0] <= cfg_data;
            CFG_IV_1: iv_word[1] <= cfg_data;
            CFG_IV_2: iv_word[2] <= cfg_data;
            CFG_IV_3: iv_word[3] <= cfg_data;
            default: ;
          endcase
        end
      end
      case (state)
        S_EXPAND: begin
          for (int k = 0; k < 7; k++) win[k] <= win[k+1];
          win[7] <= new_word;
          if (sched_idx >= 6'd8 && sched_idx[2:0] == 3'd0) begin
            rcon <= xtime(rcon);
          end
          if (sched_idx == 6'(LastSchedWord)) begin
            state <= S_IDLE;
          end
          sched_idx <= sched_idx + 6'd1;
        end
        S_IDLE: begin
          if (in_acc) begin
            blk <= {block_high, block_low};
            dec <= decrypt;
            step <= '0;
            state <= S_READ;
            if (first_block) begin
              if (decrypt) begin
                st <= {block_high, block_low} ^ {iv_word[3], iv_word[2]};
                chain_after <= {iv_word[1], iv_word[0]};
              end else begin
                st <= {block_high, block_low} ^ {iv_word[1], iv_word[0]};
                chain_after <= {iv_word[3], iv_word[2]};
              end
            end else begin
              st <= {block_high, block_low} ^ chain_before;
            end
          end
        end
        S_READ: state <= S_ROUND;
        S_ROUND: begin
          st <= st_next;
          step <= step + 4'd1;
          if (last_step) begin
            chain_before <= st_next ^ chain_after;
            chain_after <= blk;
            {result_high, result_low} <= st_next ^ chain_after;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/aig_checker.sv
`timescale 1ns / 1ps
module aig_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] result_low,
  input logic [63:0] result_high
);

  // one word in flight at a time
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("block not busy after accepting a word");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_low) && $stable(result_high)))
    else $error("stalled result changed");

endmodule

bind aes256_ige_cipher_unit aig_checker u_aig_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .result_low(result_low),
  .result_high(result_high)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import aig_pkg::*;

  typedef struct packed {
    logic        iv_reload;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        dec;
    logic        first;
    logic        typed;
    logic [63:0] exp_lo;
    logic [63:0] exp_hi;
  } vec_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [63:0] block_low = '0;
  logic [63:0] block_high = '0;
  logic        decrypt = 0;
  logic        first_block = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] result_low;
  logic [63:0] result_high;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // predictor state
  logic [63:0]  key_reg [4];
  logic [63:0]  iv_reg [4];
  logic [127:0] chain_pre;
  logic [127:0] chain_post;
  logic [127:0] round_key [15];
  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];

  logic [127:0] pending_blocks [$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           out_gap = 0;
  bit           no_idle = 0;
  vec_row_t     vec_rows [12];

  always #1 clk = ~clk;

  aes256_ige_cipher_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .block_low(block_low), .block_high(block_high),
    .decrypt(decrypt), .first_block(first_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_low(result_low), .result_high(result_high),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] ginv(logic [7:0] x);
    logic [7:0] r;
    r = 1;
    // x^254, zero stays zero
    for (int i = 0; i < 254; i++) r = gmul(r, x);
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [31:0] mix_word(logic [31:0] c, logic [7:0] m0, logic [7:0] m1,
                                           logic [7:0] m2, logic [7:0] m3);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[7:0]; a1 = c[15:8]; a2 = c[23:16]; a3 = c[31:24];
    return {gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0),
            gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1),
            gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2),
            gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3)};
  endfunction

  function automatic void build_schedule();
    logic [7:0] w [240];
    logic [7:0] t [4];
    logic [7:0] tmp;
    logic [7:0] rcon;
    rcon = 1;
    for (int i = 0; i < 32; i++) w[i] = key_reg[i >> 3][8 * (i & 7) +: 8];
    for (int i = 8; i < 60; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[4 * (i - 1) + j];
      if ((i & 7) == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int j = 0; j < 4; j++) t[j] = fwd_sub[t[j]];
        t[0] ^= rcon;
        rcon = rcon[7] ? ({rcon[6:0], 1'b0} ^ 8'h1b) : {rcon[6:0], 1'b0};
      end else if ((i & 7) == 4) begin
        for (int j = 0; j < 4; j++) t[j] = fwd_sub[t[j]];
      end
      for (int j = 0; j < 4; j++) w[4 * i + j] = w[4 * (i - 8) + j] ^ t[j];
    end
    for (int k = 0; k < 15; k++)
      for (int i = 0; i < 16; i++) round_key[k][8 * i +: 8] = w[16 * k + i];
  endfunction

  function automatic logic [127:0] aes_encrypt(logic [127:0] s);
    logic [127:0] t;
    s ^= round_key[0];
    for (int rnd = 1; rnd <= 14; rnd++) begin
      for (int i = 0; i < 16; i++) t[8 * i +: 8] = fwd_sub[s[8 * i +: 8]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          s[8 * (r + 4 * c) +: 8] = t[8 * (r + 4 * ((c + r) & 3)) +: 8];
      if (rnd != 14)
        for (int c = 0; c < 4; c++) s[32 * c +: 32] = mix_word(s[32 * c +: 32], 2, 3, 1, 1);
      s ^= round_key[rnd];
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_decrypt(logic [127:0] s);
    logic [127:0] t;
    s ^= round_key[14];
    for (int rnd = 14; rnd >= 1; rnd--) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[8 * (r + 4 * ((c + r) & 3)) +: 8] = s[8 * (r + 4 * c) +: 8];
      for (int i = 0; i < 16; i++) s[8 * i +: 8] = inv_sub[t[8 * i +: 8]];
      s ^= round_key[rnd - 1];
      if (rnd != 1)
        for (int c = 0; c < 4; c++) s[32 * c +: 32] = mix_word(s[32 * c +: 32], 14, 11, 13, 9);
    end
    return s;
  endfunction

  // one ige step on the predictor state
  function automatic logic [127:0] ige_step(logic [127:0] blk, logic dec, logic first);
    logic [127:0] res;
    if (first) begin
      chain_pre  = dec ? {iv_reg[3], iv_reg[2]} : {iv_reg[1], iv_reg[0]};
      chain_post = dec ? {iv_reg[1], iv_reg[0]} : {iv_reg[3], iv_reg[2]};
    end
    res = dec ? aes_decrypt(blk ^ chain_pre) : aes_encrypt(blk ^ chain_pre);
    res ^= chain_post;
    chain_pre = res;
    chain_post = blk;
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // caller sits at a falling edge
  task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic dec, logic first,
                            logic typed, logic [127:0] typed_res);
    int gap;
    logic [127:0] res;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    block_low = lo;
    block_high = hi;
    decrypt = dec;
    first_block = first;
    do @(posedge clk); while (in_stall);
    res = ige_step({hi, lo}, dec, first);
    pending_blocks.push_back(typed ? typed_res : res);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending_blocks.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_KEY_3) begin
      key_reg[idx] = val;
      build_schedule();
    end else begin
      iv_reg[idx - CFG_IV_0] = val;
    end
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // result side
  always @(posedge clk) begin
    logic [127:0] exp_blk;
    if (out_valid && !out_stall) begin
      out_gap = no_idle ? 0 : $urandom_range(0, 17);
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected result word %h_%h", $time, result_high, result_low);
        errors++;
      end else begin
        exp_blk = pending_blocks.pop_front();
        if (result_low !== exp_blk[63:0]) begin
          $display("%0t: result_low expected %h actual %h", $time, exp_blk[63:0], result_low);
          errors++;
        end
        if (result_high !== exp_blk[127:64]) begin
          $display("%0t: result_high expected %h actual %h", $time, exp_blk[127:64],
                   result_high);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_stall <= 1;
      out_gap--;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == 4000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    int msg_left;
    logic msg_dec;
    int sent;
    for (int i = 0; i < 256; i++) begin
      b = ginv(i[7:0]);
      fwd_sub[i] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_sub[fwd_sub[i]] = i[7:0];
    for (int i = 0; i < 4; i++) begin
      key_reg[i] = '0;
      iv_reg[i] = '0;
    end
    chain_pre = '0;
    chain_post = '0;
    build_schedule();

    vec_rows = '{
      // known answer for the standard aes-256 key, iv all zero
      '{1'b0, 64'h7766554433221100, 64'hffeeddccbbaa9988, 1'b0, 1'b1, 1'b1,
        64'hbf456751cab7a28e, 64'h8960494b9049fcea},
      '{1'b0, 64'hbf456751cab7a28e, 64'h8960494b9049fcea, 1'b1, 1'b1, 1'b1,
        64'h7766554433221100, 64'hffeeddccbbaa9988},
      '{1'b0, 64'h0, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      // direction flips without a new message
      '{1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
      '{1'b0, 64'h8000000000000001, 64'h0000000180000000, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      // iv rewritten mid-message, only the next first word sees it
      '{1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{1'b0, 64'h0, '1, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, 64'h0, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
      '{1'b0, 64'h1, 64'h8000000000000000, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
      '{1'b0, 64'hffffffff00000000, 64'h00000000ffffffff, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // blocks under the reset key and iv
    send_block('1, '1, 1'b0, 1'b1, 1'b0, '0);
    send_block(64'h0, 64'h0, 1'b1, 1'b0, 1'b0, '0);
    drain();
    write_reg(CFG_KEY_0, 64'h0706050403020100);
    write_reg(CFG_KEY_0 + 3'd1, 64'h0f0e0d0c0b0a0908);
    write_reg(CFG_KEY_0 + 3'd2, 64'h1716151413121110);
    write_reg(CFG_KEY_3, 64'h1f1e1d1c1b1a1918);
    for (int i = 0; i < 12; i++) begin
      if (vec_rows[i].iv_reload) begin
        drain();
        write_reg(CFG_IV_0, 64'h0011223344556677);
        write_reg(CFG_IV_1, '1);
        write_reg(CFG_IV_2, 64'h8899aabbccddeeff);
        write_reg(CFG_IV_3, 64'hf0f0f0f00f0f0f0f);
      end
      send_block(vec_rows[i].lo, vec_rows[i].hi, vec_rows[i].dec, vec_rows[i].first,
                 vec_rows[i].typed, {vec_rows[i].exp_hi, vec_rows[i].exp_lo});
    end

    sent = 0;
    for (int phase = 0; phase < 12; phase++) begin
      drain();
      no_idle = (phase % 4 == 3);
      for (int k = 0; k < 8; k++) begin
        if (phase == 0)
          write_reg(CFG_KEY_0 + 3'(k), '1);
        else if (phase == 1)
          write_reg(CFG_KEY_0 + 3'(k), '0);
        else if ($urandom_range(0, 2) != 0)
          write_reg(CFG_KEY_0 + 3'(k), rand_word());
      end
      msg_left = 0;
      msg_dec = 0;
      for (int n = 0; n < 128; n++) begin
        if (msg_left == 0) begin
          msg_left = $urandom_range(1, 12);
          msg_dec = 1'($urandom_range(0, 1));
          send_block(rand_word(), rand_word(), msg_dec, 1'b1, 1'b0, '0);
        end else if ($urandom_range(0, 9) == 0) begin
          // stray word: random direction, random first flag
          send_block(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          send_block(rand_word(), rand_word(), msg_dec, 1'b0, 1'b0, '0);
        end
        msg_left--;
        sent++;
      end
    end

    drain();
    if (errors == 0 && pending_blocks.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
